@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the allocator rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check, sampled on the rising edge, off while in reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("allocator check failed");

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ rtl/core/gfba_pkg.sv @@
// shared types and constants of the grouped free-block allocator
// depends on nothing; imported by the interfaces and all modules
package gfba_pkg;

    // block numbers are fixed by the 10-bit index field
    localparam int NUM_BLOCKS = 1024;
    localparam int IDX_W      = 10;
    // block number or the "none" marker, and free counts up to NUM_BLOCKS
    localparam int BLK_W      = 11;
    localparam int CNT_W      = 11;
    localparam int ST_W       = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOFREE  = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [ST_W-1:0] ST_UNUSED  = 3'd3;
    localparam logic [ST_W-1:0] ST_ALLFREE = 3'd4;

    localparam logic [BLK_W-1:0] NO_BLOCK = BLK_W'(NUM_BLOCKS);

    // controller to datapath
    typedef struct packed {
        logic clr_step;   // write one formatted row and clear one map bit
        logic capture;    // latch the request, read its map bit
        logic check;      // decide, update state, load the result register
        logic fetch;      // read the list row of the new head
        logic load;       // move the fetched row into the stack
        logic newrow;     // write the stack into the new head's row
    } gfba_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic need_fetch;
        logic need_newrow;
    } gfba_stat_t;

endpackage

@@ rtl/core/gfba_req_if.sv @@
// request channel of the allocator: valid/ready plus command and block number
// depends on gfba_pkg
interface gfba_req_if import gfba_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink (input valid, input cmd, input block_index, output ready);

endinterface

@@ rtl/core/gfba_rsp_if.sv @@
// result channel of the allocator: valid/ready plus grant, status and count
// depends on gfba_pkg
interface gfba_rsp_if import gfba_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] granted_block;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] free_blocks;

    modport source (output valid, output granted_block, output status,
                    output free_blocks, input ready);
    modport sink (input valid, input granted_block, input status,
                  input free_blocks, output ready);

endinterface

@@ rtl/core/gfba_ctrl.sv @@
// sequencing state machine of the allocator: clearing pass, handshakes, steps
// depends on gfba_pkg; drives gfba_dp through gfba_cmd_t
module gfba_ctrl import gfba_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  gfba_stat_t stat,
    output gfba_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_LOAD   = 3'd4;
    localparam logic [2:0] S_NEWROW = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // hold until the result register can take the item
                if (out_free)
                begin
                    cmd.check = 1'b1;
                    if (stat.need_fetch)
                    begin
                        state_next = S_FETCH;
                    end
                    else if (stat.need_newrow)
                    begin
                        state_next = S_NEWROW;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_IDLE;
            end
            S_NEWROW:
            begin
                cmd.newrow = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.check)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ rtl/core/gfba_dp.sv @@
// datapath of the allocator: stack, head, count, used map, list memory, result
// depends on gfba_pkg; steered by gfba_ctrl through gfba_cmd_t
module gfba_dp import gfba_pkg::*; #(
    parameter int GROUP_SIZE = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gfba_cmd_t        cmd,
    output gfba_stat_t       stat,
    input  logic             req_cmd,
    input  logic [IDX_W-1:0] req_block_index,
    output logic [IDX_W-1:0] rsp_granted_block,
    output logic [ST_W-1:0]  rsp_status,
    output logic [CNT_W-1:0] rsp_free_blocks
);

    localparam int TOP_W     = $clog2(GROUP_SIZE);
    localparam int LAST_HEAD = (NUM_BLOCKS / GROUP_SIZE - 1) * GROUP_SIZE;
    localparam int RST_LINK  = (NUM_BLOCKS / GROUP_SIZE > 1) ? GROUP_SIZE : NUM_BLOCKS;
    localparam int RST_TOP   = (NUM_BLOCKS - 1) % GROUP_SIZE;

    typedef logic [GROUP_SIZE-1:0][BLK_W-1:0] row_t;

    // memories
    row_t list_mem [NUM_BLOCKS];
    logic used_mem [NUM_BLOCKS];
    row_t list_rd_reg;
    logic used_rd_reg;

    // allocator state
    row_t             stack_reg;
    logic [BLK_W-1:0] head_reg;
    logic [CNT_W-1:0] total_reg;
    logic [TOP_W-1:0] top_reg;

    // captured request
    logic             cmd_reg;
    logic [IDX_W-1:0] idx_reg;

    // clearing pass
    logic [IDX_W-1:0] clr_row_reg;
    logic [TOP_W-1:0] clr_phase_reg;
    row_t             fmt_row;

    // decision
    logic             is_free;
    logic             nofree;
    logic             alloc_switch;
    logic             new_group;
    logic             range_err;
    logic             op_ok;
    logic [BLK_W-1:0] got;
    logic [TOP_W-1:0] top_inc;
    logic [IDX_W-1:0] res_granted;
    logic [ST_W-1:0]  res_status;
    logic [CNT_W-1:0] res_free;

    // memory ports
    logic             list_we;
    logic [IDX_W-1:0] list_wa;
    row_t             list_wd;
    logic             used_we;
    logic [IDX_W-1:0] used_wa;
    logic             used_wd;

    assign is_free      = (cmd_reg == CMD_FREE);
    assign nofree       = (head_reg >= NO_BLOCK) || (total_reg == '0);
    assign alloc_switch = (top_reg == '0);
    assign new_group    = (total_reg == '0) || (top_reg == TOP_W'(GROUP_SIZE - 1));
    assign range_err    = (BLK_W'(idx_reg) >= NO_BLOCK);
    assign got          = alloc_switch ? head_reg : stack_reg[top_reg];
    assign top_inc      = top_reg + 1'b1;

    always_comb
    begin
        res_granted = '0;
        res_free    = total_reg;
        op_ok       = 1'b0;
        if (!is_free)
        begin
            if (nofree)
            begin
                res_status = ST_NOFREE;
            end
            else
            begin
                res_status  = ST_OK;
                op_ok       = 1'b1;
                res_granted = got[IDX_W-1:0];
                res_free    = total_reg - 1'b1;
            end
        end
        else if (range_err)
        begin
            res_status = ST_RANGE;
        end
        else if (!used_rd_reg)
        begin
            res_status = ST_UNUSED;
        end
        else if (total_reg >= CNT_W'(NUM_BLOCKS))
        begin
            res_status = ST_ALLFREE;
        end
        else
        begin
            res_status = ST_OK;
            op_ok      = 1'b1;
            res_free   = total_reg + 1'b1;
        end
    end

    assign stat.need_fetch  = op_ok && !is_free && alloc_switch && (stack_reg[0] < NO_BLOCK);
    assign stat.need_newrow = op_ok && is_free && new_group;
    assign stat.clr_last    = (clr_row_reg == IDX_W'(NUM_BLOCKS - 1));

    // formatted row: a group head links to the next head and lists its blocks
    always_comb
    begin
        fmt_row = '0;
        if (clr_phase_reg == '0)
        begin
            if (clr_row_reg == IDX_W'(LAST_HEAD))
            begin
                fmt_row[0] = NO_BLOCK;
            end
            else
            begin
                fmt_row[0] = BLK_W'(clr_row_reg) + BLK_W'(GROUP_SIZE);
            end
            for (int j = 1; j < GROUP_SIZE; j++)
            begin
                fmt_row[j] = BLK_W'(clr_row_reg) + BLK_W'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg   <= '0;
            clr_phase_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_phase_reg == TOP_W'(GROUP_SIZE - 1))
            begin
                clr_phase_reg <= '0;
            end
            else
            begin
                clr_phase_reg <= clr_phase_reg + 1'b1;
            end
        end
    end

    // every stack save writes the stack at the current head's row
    always_comb
    begin
        list_we = cmd.clr_step || cmd.newrow
                  || (cmd.check && op_ok && !is_free && alloc_switch)
                  || (cmd.check && op_ok && is_free && new_group && (head_reg < NO_BLOCK));
        list_wa = cmd.clr_step ? clr_row_reg : head_reg[IDX_W-1:0];
        list_wd = cmd.clr_step ? fmt_row : stack_reg;
    end

    always_comb
    begin
        used_we = cmd.clr_step || (cmd.check && op_ok && (is_free || (got < NO_BLOCK)));
        if (cmd.clr_step)
        begin
            used_wa = clr_row_reg;
        end
        else if (is_free)
        begin
            used_wa = idx_reg;
        end
        else
        begin
            used_wa = got[IDX_W-1:0];
        end
        used_wd = !cmd.clr_step && !is_free;
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_wa] <= list_wd;
        end
        if (cmd.fetch)
        begin
            list_rd_reg <= list_mem[head_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        if (cmd.capture)
        begin
            used_rd_reg <= used_mem[req_block_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= req_cmd;
            idx_reg <= req_block_index;
        end
        if (cmd.check)
        begin
            rsp_granted_block <= res_granted;
            rsp_status        <= res_status;
            rsp_free_blocks   <= res_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            total_reg <= CNT_W'(NUM_BLOCKS);
            top_reg   <= TOP_W'(RST_TOP);
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                stack_reg[j] <= (j == 0) ? BLK_W'(RST_LINK) : BLK_W'(j);
            end
        end
        else if (cmd.check && op_ok)
        begin
            if (!is_free)
            begin
                total_reg <= total_reg - 1'b1;
                if (alloc_switch)
                begin
                    // head goes out, link becomes the head; its row follows
                    head_reg <= stack_reg[0];
                    top_reg  <= TOP_W'(GROUP_SIZE - 1);
                    if (stack_reg[0] >= NO_BLOCK)
                    begin
                        for (int j = 0; j < GROUP_SIZE; j++)
                        begin
                            stack_reg[j] <= NO_BLOCK;
                        end
                    end
                end
                else
                begin
                    stack_reg[top_reg] <= NO_BLOCK;
                    top_reg            <= top_reg - 1'b1;
                end
            end
            else
            begin
                total_reg <= total_reg + 1'b1;
                if (new_group)
                begin
                    stack_reg[0] <= head_reg;
                    for (int j = 1; j < GROUP_SIZE; j++)
                    begin
                        stack_reg[j] <= NO_BLOCK;
                    end
                    head_reg <= BLK_W'(idx_reg);
                    top_reg  <= '0;
                end
                else
                begin
                    stack_reg[top_inc] <= BLK_W'(idx_reg);
                    top_reg            <= top_inc;
                end
            end
        end
        else if (cmd.load)
        begin
            stack_reg <= list_rd_reg;
        end
    end

endmodule

@@ rtl/core/grouped_free_block_allocator.sv @@
// top level of the grouped free-block allocator
// depends on gfba_pkg, gfba_req_if, gfba_rsp_if, gfba_ctrl, gfba_dp, assert_macros.svh
//
// usage
//   req: one item per allocate (cmd 0) or free (cmd 1, block_index names the block)
//   rsp: one item per request, in order: granted_block, status, free_blocks after it
//   both channels move an item when valid and ready are high at a rising edge
// timing
//   one request is worked on at a time; req.ready is high only while idle
//   the result is registered in the check step, which waits while the output register is full
//   plain allocate, plain free and every failed request: idle, check
//   free that starts a new group: idle, check, newrow (extra list memory write of the new row)
//   allocate of a head with a next group: idle, check (row write), fetch (read), load; else idle, check
//   the list memory has one write and one registered read port, one row a cycle
// reset
//   after rst_n rises a clearing pass formats the list memory and clears the
//   used map, one row per cycle, all NUM_BLOCKS (1024) rows; req.ready stays low
// stalls
//   a result waits in the output register while rsp.ready is low; the next
//   request is still taken, and its result holds until the register frees up
`include "assert_macros.svh"

module grouped_free_block_allocator import gfba_pkg::*; #(
    parameter int GROUP_SIZE = 16
) (
    input logic        clk,
    input logic        rst_n,
    gfba_req_if.sink   req,
    gfba_rsp_if.source rsp
);

    gfba_cmd_t  ctl_cmd;
    gfba_stat_t dp_stat;

    // sequencing: handshakes, clearing pass, multi-step group moves
    gfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (ctl_cmd)
    );

    // storage and decisions: stack, head, count, used map, list memory
    gfba_dp #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (ctl_cmd),
        .stat              (dp_stat),
        .req_cmd           (req.cmd),
        .req_block_index   (req.block_index),
        .rsp_granted_block (rsp.granted_block),
        .rsp_status        (rsp.status),
        .rsp_free_blocks   (rsp.free_blocks)
    );

    // no request is taken while the memories are being formatted
    `ASSERT_IMP(a_no_ready_in_clear, clk, rst_n, ctl_cmd.clr_step, !req.ready)
    // a taken request closes the input until its work is done
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready)
    // the free count never passes the number of blocks
    `ASSERT_IMP(a_count_bound, clk, rst_n, rsp.valid, rsp.free_blocks <= CNT_W'(NUM_BLOCKS))
    // a failed request never grants a block
    `ASSERT_IMP(a_fail_no_grant, clk, rst_n, rsp.valid && (rsp.status != ST_OK), rsp.granted_block == '0)

endmodule
